@@ hdl/mlft_pkg.sv @@
package mlft_pkg;

   localparam int TABLE_DEPTH     = 64;
   localparam int MAC_W           = 48;
   localparam int PORT_W          = 4;
   localparam int ADDR_W          = $clog2(TABLE_DEPTH);
   localparam int CNT_W           = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W         = MAC_W + PORT_W;
   localparam int REQ_QUEUE_DEPTH = 2;
   localparam int REQ_PTR_W       = $clog2(REQ_QUEUE_DEPTH);
   localparam int REQ_CNT_W       = $clog2(REQ_QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      LS_UNCHANGED = 2'd0,
      LS_NEW       = 2'd1,
      LS_MOVED     = 2'd2,
      LS_FULL      = 2'd3
   } learn_status_type;

   // classified request, as queued between front and back
   typedef struct packed {
      logic [MAC_W-1:0]  dst_mac;
      logic [MAC_W-1:0]  src_mac;
      logic [PORT_W-1:0] ingress_port;
      logic              broadcast;
      logic              self_dst;
   } req_type;

   // request queue read side
   typedef struct packed {
      logic    valid;
      req_type data;
   } req_q_type;

   typedef struct packed {
      logic             flood;
      logic [PORT_W-1:0] egress_port;
      learn_status_type learn_status;
   } rsp_type;

endpackage

@@ hdl/mlft_ram.sv @@
module mlft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/mlft_front.sv @@
module mlft_front import mlft_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [MAC_W-1:0]  req_dst_mac,
   input  logic [MAC_W-1:0]  req_src_mac,
   input  logic [PORT_W-1:0] req_ingress_port,
   output req_q_type         req_q,
   input  logic              req_q_pop
);

   req_type               slot_ff [REQ_QUEUE_DEPTH];
   req_type               req_in;
   logic [REQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [REQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [REQ_CNT_W-1:0]  count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      req_in.dst_mac      = req_dst_mac;
      req_in.src_mac      = req_src_mac;
      req_in.ingress_port = req_ingress_port;
      req_in.broadcast    = &req_dst_mac;
      req_in.self_dst     = (req_dst_mac == req_src_mac);
   end

   assign full    = (count_ff == REQ_CNT_W'(REQ_QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = req_q_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == REQ_PTR_W'(REQ_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == REQ_PTR_W'(REQ_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= req_in;
      end
   end

   assign req_q.valid = (count_ff != '0);
   assign req_q.data  = slot_ff[rd_ptr_ff];

endmodule

@@ hdl/mlft_back.sv @@
module mlft_back import mlft_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  req_q_type req_q,
   output logic      req_q_pop,
   output logic      empty,
   input  logic      pop,
   output rsp_type   rsp
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } back_state_type;

   back_state_type    state_ff, state_in;
   req_type           cur_ff, cur_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              data_vld_ff, data_vld_in;
   logic [ADDR_W-1:0] data_idx_ff, data_idx_in;
   logic              src_hit_ff, src_hit_in;
   logic [ADDR_W-1:0] src_idx_ff, src_idx_in;
   logic [PORT_W-1:0] src_port_ff, src_port_in;
   logic              dst_hit_ff, dst_hit_in;
   logic [PORT_W-1:0] dst_port_ff, dst_port_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic [MAC_W-1:0]  ram_mac;
   logic [PORT_W-1:0] ram_port;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              issue;
   logic              finish;
   learn_status_type  status;

   assign ram_mac  = rd_data[ENTRY_W-1:PORT_W];
   assign ram_port = rd_data[PORT_W-1:0];
   assign issue    = (state_ff == ST_SCAN) && (rd_idx_ff < fill_ff);
   assign rd_en    = issue;
   assign finish   = (state_ff == ST_UPDATE) && (!rsp_valid_ff || pop);

   always_comb begin
      if (src_hit_ff) begin
         status = (src_port_ff == cur_ff.ingress_port) ? LS_UNCHANGED : LS_MOVED;
      end else if (fill_ff == CNT_W'(TABLE_DEPTH)) begin
         status = LS_FULL;
      end else begin
         status = LS_NEW;
      end
   end

   always_comb begin
      rsp_in.learn_status = status;
      rsp_in.flood        = 1'b1;
      rsp_in.egress_port  = '0;
      if (cur_ff.broadcast) begin
         rsp_in.flood = 1'b1;
      end else if (cur_ff.self_dst) begin
         if (status != LS_FULL) begin
            rsp_in.flood       = 1'b0;
            rsp_in.egress_port = cur_ff.ingress_port;
         end
      end else if (dst_hit_ff) begin
         rsp_in.flood       = 1'b0;
         rsp_in.egress_port = dst_port_ff;
      end
   end

   assign wr_en   = finish && ((status == LS_MOVED) || (status == LS_NEW));
   assign wr_addr = (status == LS_MOVED) ? src_idx_ff : fill_ff[ADDR_W-1:0];

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      fill_in     = fill_ff;
      rd_idx_in   = rd_idx_ff;
      data_vld_in = 1'b0;
      data_idx_in = data_idx_ff;
      src_hit_in  = src_hit_ff;
      src_idx_in  = src_idx_ff;
      src_port_in = src_port_ff;
      dst_hit_in  = dst_hit_ff;
      dst_port_in = dst_port_ff;
      req_q_pop   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_q.valid) begin
               req_q_pop  = 1'b1;
               cur_in     = req_q.data;
               rd_idx_in  = '0;
               src_hit_in = 1'b0;
               dst_hit_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_idx_in   = rd_idx_ff + 1'b1;
               data_vld_in = 1'b1;
               data_idx_in = rd_idx_ff[ADDR_W-1:0];
            end else if (!data_vld_ff) begin
               state_in = ST_UPDATE;
            end
            if (data_vld_ff) begin
               if (ram_mac == cur_ff.src_mac) begin
                  src_hit_in  = 1'b1;
                  src_idx_in  = data_idx_ff;
                  src_port_in = ram_port;
               end
               if (ram_mac == cur_ff.dst_mac) begin
                  dst_hit_in  = 1'b1;
                  dst_port_in = ram_port;
               end
            end
         end
         ST_UPDATE: begin
            if (finish) begin
               if (status == LS_NEW) begin
                  fill_in = fill_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rd_idx_ff   <= rd_idx_in;
      data_idx_ff <= data_idx_in;
      src_hit_ff  <= src_hit_in;
      src_idx_ff  <= src_idx_in;
      src_port_ff <= src_port_in;
      dst_hit_ff  <= dst_hit_in;
      dst_port_ff <= dst_port_in;
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   mlft_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({cur_ff.src_mac, cur_ff.ingress_port}),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign empty = !rsp_valid_ff;
   assign rsp   = rsp_ff;

endmodule

@@ hdl/mac_learning_forwarding_table.sv @@
// A pushed request waits in the request queue until the back end, in ST_IDLE, takes it;
//   ST_SCAN then reads the N entries learned so far (0..TABLE_DEPTH), and ST_UPDATE
//   registers the result once the result register is free or being popped. Requests are
//   handled one at a time by the linear scan of the table RAM (one read port, one entry per
//   cycle); a 2-deep request queue and the result register let push and pop run mid-scan.
// Reset: synchronous; empties the request queue and the result register, clears the table fill count,
//   so all entries read as unused.
module mac_learning_forwarding_table import mlft_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [MAC_W-1:0]  req_dst_mac,
   input  logic [MAC_W-1:0]  req_src_mac,
   input  logic [PORT_W-1:0] req_ingress_port,
   output logic              empty,
   input  logic              pop,
   output logic              rsp_flood,
   output logic [PORT_W-1:0] rsp_egress_port,
   output logic [1:0]        rsp_learn_status
);

   req_q_type req_q;
   logic      req_q_pop;
   rsp_type   rsp;

   mlft_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_dst_mac      (req_dst_mac),
      .req_src_mac      (req_src_mac),
      .req_ingress_port (req_ingress_port),
      .req_q            (req_q),
      .req_q_pop        (req_q_pop)
   );

   mlft_back u_back (
      .clock     (clock),
      .reset     (reset),
      .req_q     (req_q),
      .req_q_pop (req_q_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_flood        = rsp.flood;
   assign rsp_egress_port  = rsp.egress_port;
   assign rsp_learn_status = rsp.learn_status;

endmodule
